// ----- hdl/sdp_pkg.sv -----
// ----------------------------------------------------------------------------
// Scale degree pitch package
// Shared types, codes and scale tables for the scale degree pitch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdp_pkg;

    localparam int unsigned ROOT_W   = 4;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned PITCH_W  = 7;
    localparam int unsigned AMOUNT_W = 8;
    localparam int unsigned VALUE_W  = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_TO_PITCH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TO_DEGREE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TRANSPOSE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_MAJOR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MINOR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PENTA = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND = 2'd1;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [KIND_W-1:0] kind;
    } t_scale_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               in_scale;
    } t_result;

    function automatic logic [KIND_W-1:0] f_norm_kind(input logic [KIND_W-1:0] kind);
        logic [KIND_W-1:0] k;
        k = (kind == KIND_MINOR || kind == KIND_PENTA) ? kind : KIND_MAJOR;
        return k;
    endfunction

    function automatic logic [2:0] f_count(input logic [KIND_W-1:0] kind);
        logic [2:0] n;
        n = (kind == KIND_PENTA) ? 3'd5 : 3'd7;
        return n;
    endfunction

    function automatic logic [3:0] f_step(input logic [KIND_W-1:0] kind,
                                          input logic [2:0] idx);
        logic [3:0] s;
        s = 4'd0;
        unique case (kind)
            KIND_MINOR: begin
                unique case (idx)
                    3'd0: s = 4'd0;
                    3'd1: s = 4'd2;
                    3'd2: s = 4'd3;
                    3'd3: s = 4'd5;
                    3'd4: s = 4'd7;
                    3'd5: s = 4'd9;
                    3'd6: s = 4'd10;
                    default: s = 4'd0;
                endcase
            end
            KIND_PENTA: begin
                unique case (idx)
                    3'd0: s = 4'd0;
                    3'd1: s = 4'd3;
                    3'd2: s = 4'd5;
                    3'd3: s = 4'd7;
                    3'd4: s = 4'd10;
                    default: s = 4'd0;
                endcase
            end
            default: begin
                unique case (idx)
                    3'd0: s = 4'd0;
                    3'd1: s = 4'd2;
                    3'd2: s = 4'd4;
                    3'd3: s = 4'd5;
                    3'd4: s = 4'd7;
                    3'd5: s = 4'd9;
                    3'd6: s = 4'd11;
                    default: s = 4'd0;
                endcase
            end
        endcase
        return s;
    endfunction

    // Returns {hit, one-based degree}; a miss gives degree one.
    function automatic logic [3:0] f_class_deg(input logic [KIND_W-1:0] kind,
                                               input logic [3:0] cls);
        logic [3:0] r;
        r = {1'b0, 3'd1};
        unique case (kind)
            KIND_MINOR: begin
                unique case (cls)
                    4'd0:  r = {1'b1, 3'd1};
                    4'd2:  r = {1'b1, 3'd2};
                    4'd3:  r = {1'b1, 3'd3};
                    4'd5:  r = {1'b1, 3'd4};
                    4'd7:  r = {1'b1, 3'd5};
                    4'd9:  r = {1'b1, 3'd6};
                    4'd10: r = {1'b1, 3'd7};
                    default: r = {1'b0, 3'd1};
                endcase
            end
            KIND_PENTA: begin
                unique case (cls)
                    4'd0:  r = {1'b1, 3'd1};
                    4'd3:  r = {1'b1, 3'd2};
                    4'd5:  r = {1'b1, 3'd3};
                    4'd7:  r = {1'b1, 3'd4};
                    4'd10: r = {1'b1, 3'd5};
                    default: r = {1'b0, 3'd1};
                endcase
            end
            default: begin
                unique case (cls)
                    4'd0:  r = {1'b1, 3'd1};
                    4'd2:  r = {1'b1, 3'd2};
                    4'd4:  r = {1'b1, 3'd3};
                    4'd5:  r = {1'b1, 3'd4};
                    4'd7:  r = {1'b1, 3'd5};
                    4'd9:  r = {1'b1, 3'd6};
                    4'd11: r = {1'b1, 3'd7};
                    default: r = {1'b0, 3'd1};
                endcase
            end
        endcase
        return r;
    endfunction

    // Quotient by the scale length for values up to 128, by reciprocal multiply.
    function automatic logic [4:0] f_div_len(input logic [KIND_W-1:0] kind,
                                             input logic [7:0] x);
        logic [15:0] prod;
        prod = (kind == KIND_PENTA) ? (16'(x) * 16'd205) : (16'(x) * 16'd147);
        return prod[14:10];
    endfunction

    // Quotient by twelve for values up to 127.
    function automatic logic [3:0] f_div12(input logic [6:0] x);
        logic [14:0] prod;
        prod = 15'(x) * 15'd171;
        return prod[14:11];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sdp_core.sv -----
// ----------------------------------------------------------------------------
// Scale degree pitch mapping logic
// Combinational mapping of one registered request to its result.
// ----------------------------------------------------------------------------
`default_nettype none

module sdp_core (
    input  wire logic [sdp_pkg::REQ_W-1:0]    i_req,
    input  wire logic [sdp_pkg::PITCH_W-1:0]  i_pitch,
    input  wire logic [sdp_pkg::AMOUNT_W-1:0] i_amount,
    input  wire sdp_pkg::t_scale_cfg          i_cfg,
    output sdp_pkg::t_result                  o_result
);
    import sdp_pkg::*;

    logic [KIND_W-1:0] kind;
    logic [2:0]        n;
    logic [9:0]        root10;

    logic [6:0] off_m1;
    logic [4:0] q0;
    logic [7:0] r0_full;
    logic [9:0] val0;

    logic [3:0] oct1;
    logic [6:0] cls1_full;
    logic [3:0] cd1;
    logic [9:0] val1;

    logic signed [8:0] d;
    logic [3:0]        oct_pos;
    logic [6:0]        cls_pos;
    logic signed [6:0] oct2;
    logic [3:0]        cls2;
    logic [3:0]        cd2;
    logic              hit2;
    logic [7:0]        mag;
    logic [4:0]        qa;
    logic [7:0]        ra_full;
    logic signed [6:0] oct_s;
    logic signed [4:0] rem_s;
    logic signed [6:0] oct_t;
    logic signed [4:0] deg_t;
    logic signed [6:0] oct_f;
    logic signed [4:0] deg_f;
    logic signed [4:0] n_s;
    logic [3:0]        step2;
    logic [9:0]        oct10;
    logic [9:0]        val2;

    always_comb begin
        kind   = f_norm_kind(i_cfg.kind);
        n      = f_count(kind);
        n_s    = {2'b00, n};
        root10 = {6'd0, i_cfg.root};

        // Degree offset to pitch.
        off_m1  = $signed(i_amount) < 8'sd1 ? 7'd0 : (i_amount[6:0] - 7'd1);
        q0      = f_div_len(kind, {1'b0, off_m1});
        r0_full = {1'b0, off_m1} - 8'(q0) * 8'(n);
        val0    = (10'(q0) << 3) + (10'(q0) << 2) + root10
                + {6'd0, f_step(kind, r0_full[2:0])};

        // Pitch to degree offset, root ignored.
        oct1      = f_div12(i_pitch);
        cls1_full = i_pitch - 7'(oct1) * 7'd12;
        cd1       = f_class_deg(kind, cls1_full[3:0]);
        val1      = 10'(oct1) * 10'(n) + {7'd0, cd1[2:0]};

        // Transpose by scale steps.
        d       = $signed({2'b00, i_pitch}) - $signed({5'd0, i_cfg.root});
        oct_pos = f_div12(d[6:0]);
        cls_pos = d[6:0] - 7'(oct_pos) * 7'd12;
        if (d == -9'sd12) begin
            oct2 = -7'sd1;
            cls2 = 4'd0;
        end else begin
            oct2 = $signed({3'b000, oct_pos});
            cls2 = cls_pos[3:0];
        end
        cd2  = f_class_deg(kind, cls2);
        hit2 = (d == -9'sd12) || (!d[8] && cd2[3]);

        mag     = i_amount[7] ? (8'd0 - i_amount) : i_amount;
        qa      = f_div_len(kind, mag);
        ra_full = mag - 8'(qa) * 8'(n);
        oct_s   = i_amount[7] ? -$signed({2'b00, qa}) : $signed({2'b00, qa});
        rem_s   = i_amount[7] ? -$signed({2'b00, ra_full[2:0]})
                              : $signed({2'b00, ra_full[2:0]});
        oct_t   = oct2 + oct_s;
        deg_t   = $signed({2'b00, cd2[2:0]}) + rem_s;

        oct_f = oct_t;
        deg_f = deg_t;
        priority if (deg_t < 5'sd1) begin
            if (oct_t != 7'sd0) begin
                oct_f = oct_t - 7'sd1;
                deg_f = deg_t + n_s;
            end
        end else if (deg_t > n_s) begin
            oct_f = oct_t + 7'sd1;
            deg_f = deg_t - n_s;
        end

        step2 = (deg_f >= 5'sd1 && deg_f <= n_s) ? f_step(kind, 3'(deg_f - 5'sd1)) : 4'd0;
        oct10 = {{3{oct_f[6]}}, oct_f};
        val2  = (oct10 << 3) + (oct10 << 2) + root10 + {6'd0, step2};

        unique case (i_req)
            REQ_TO_PITCH: begin
                o_result.value    = val0;
                o_result.in_scale = 1'b1;
            end
            REQ_TO_DEGREE: begin
                o_result.value    = val1;
                o_result.in_scale = cd1[3];
            end
            REQ_TRANSPOSE: begin
                o_result.value    = hit2 ? val2 : {3'd0, i_pitch};
                o_result.in_scale = hit2;
            end
            default: begin
                o_result.value    = '0;
                o_result.in_scale = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/sdp_out_reg.sv -----
// ----------------------------------------------------------------------------
// Scale degree pitch result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdp_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire sdp_pkg::t_result i_result,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output sdp_pkg::t_result      o_result
);
    import sdp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    always_comb begin
        o_ready = !r_valid || i_ready;
        n_valid = o_ready ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- hdl/scale_degree_pitch_unit.sv -----
// A request is held in the request register, mapped combinationally and then
// captured in the result register. Throughput: one request per cycle unless the
// result side stalls; the request register and the result register each hold
// one item, so one request is taken while a result waits.
// Reset clears both valid flags and sets the scale to C major.
// ----------------------------------------------------------------------------
// Scale degree pitch unit
// Maps scale degrees and pitches over a configured diatonic or pentatonic scale.
// ----------------------------------------------------------------------------
`default_nettype none

module scale_degree_pitch_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pitch_in [6:0], degree_amount [14:7], zero [15]
    input  wire logic [sdp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type [1:0]
    input  wire logic [sdp_pkg::REQ_W-1:0]        s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // result_value [9:0], zero [15:10]
    output logic [sdp_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // in_scale [0]
    output logic                                  m_axis_tuser,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [sdp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sdp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sdp_pkg::*;

    t_scale_cfg          r_cfg;
    logic                r_in_valid;
    logic [REQ_W-1:0]    r_req;
    logic [PITCH_W-1:0]  r_pitch;
    logic [AMOUNT_W-1:0] r_amount;
    logic                out_ready;
    t_result             core_result;
    t_result             out_result;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_in_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.root <= '0;
            r_cfg.kind <= KIND_MAJOR;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ROOT) begin
                r_cfg.root <= i_cfg_data[ROOT_W-1:0];
            end
            if (i_cfg_index == CFG_KIND) begin
                r_cfg.kind <= i_cfg_data[KIND_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req    <= s_axis_tuser;
            r_pitch  <= s_axis_tdata[PITCH_W-1:0];
            r_amount <= s_axis_tdata[PITCH_W+AMOUNT_W-1:PITCH_W];
        end
    end

    sdp_core u_core (
        .i_req    (r_req),
        .i_pitch  (r_pitch),
        .i_amount (r_amount),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    sdp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-VALUE_W){1'b0}}, out_result.value};
    assign m_axis_tuser = out_result.in_scale;

endmodule

`default_nettype wire

// ----- tb/scale_degree_pitch_checker.sv -----
// ----------------------------------------------------------------------------
// Scale degree pitch checker
// Watches the request, result and register channels of the scale degree
// pitch unit. It keeps its own copy of the scale setting, works out the
// result of every accepted request and compares each delivered result with
// the oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scale_degree_pitch_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    input  logic                                i_req_ready,
    input  logic [sdp_pkg::IN_DATA_W-1:0]       i_req_data,
    input  logic [sdp_pkg::REQ_W-1:0]           i_req_user,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic [sdp_pkg::OUT_DATA_W-1:0]      i_res_data,
    input  logic                                i_res_user,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [sdp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sdp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_pending,
    output int                                  o_failures,
    output int                                  o_checked,
    output int                                  o_in_scale
);

    import sdp_pkg::*;

    localparam int OCTAVE    = 12;
    localparam int DUE_DEPTH = 64;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic                in_scale;
        logic [REQ_W-1:0]    req;
        logic [PITCH_W-1:0]  pitch;
        logic [AMOUNT_W-1:0] amount;
    } t_scale_result;

    t_scale_result     due_buf [DUE_DEPTH];
    int                due_head;
    int                due_tail;
    t_scale_result     due;
    logic [ROOT_W-1:0] scale_root;
    logic [KIND_W-1:0] scale_kind;

    initial begin
        o_pending  = 0;
        o_failures = 0;
        o_checked  = 0;
        o_in_scale = 0;
        due_head   = 0;
        due_tail   = 0;
        scale_root = '0;
        scale_kind = KIND_MAJOR;
    end

    function automatic int scale_step(input logic [KIND_W-1:0] kind, input int idx);
        logic [27:0] steps;
        steps = (kind == KIND_MINOR) ? 28'hA975320 :
                (kind == KIND_PENTA) ? 28'h00A7530 : 28'hB975420;
        return int'(steps[4*idx +: 4]);
    endfunction

    function automatic t_scale_result map_scale_request(
        input logic [REQ_W-1:0]    req,
        input logic [PITCH_W-1:0]  pitch,
        input logic [AMOUNT_W-1:0] amount,
        input logic [ROOT_W-1:0]   root_reg,
        input logic [KIND_W-1:0]   kind_reg
    );
        logic [KIND_W-1:0] kind;
        int                n, root, p, amt, off, oct, deg, val, i, j;
        logic              hit;
        t_scale_result     r;
        kind = (kind_reg == KIND_MINOR || kind_reg == KIND_PENTA) ? kind_reg : KIND_MAJOR;
        n    = (kind == KIND_PENTA) ? 5 : 7;
        root = int'(root_reg);
        p    = int'(pitch);
        amt  = int'($signed(amount));
        val  = 0;
        hit  = 1'b0;
        case (req)
            REQ_TO_PITCH: begin
                off = (amt < 1) ? 1 : amt;
                val = OCTAVE * ((off - 1) / n) + root + scale_step(kind, (off - 1) % n);
                hit = 1'b1;
            end
            REQ_TO_DEGREE: begin
                deg = 1;
                for (j = 0; j < n; j++) begin
                    if (!hit && scale_step(kind, j) == p % OCTAVE) begin
                        deg = j + 1;
                        hit = 1'b1;
                    end
                end
                val = (p / OCTAVE) * n + deg;
            end
            REQ_TRANSPOSE: begin
                oct = (p - root) / OCTAVE;
                deg = 0;
                for (i = oct; i <= 12 && !hit; i++) begin
                    for (j = 0; j < n; j++) begin
                        if (!hit && i * OCTAVE + root + scale_step(kind, j) == p) begin
                            deg = j + 1;
                            hit = 1'b1;
                        end
                    end
                end
                if (!hit) begin
                    val = p;
                end else begin
                    oct = oct + amt / n;
                    deg = deg + amt % n;
                    // In octave zero a step below the first degree does not wrap.
                    while (deg < 1 && oct != 0) begin
                        oct = oct - 1;
                        deg = deg + n;
                    end
                    while (deg > n) begin
                        oct = oct + 1;
                        deg = deg - n;
                    end
                    val = OCTAVE * oct + root;
                    if (deg >= 1 && deg <= n) begin
                        val = val + scale_step(kind, deg - 1);
                    end
                end
            end
            default: begin
                val = 0;
                hit = 1'b0;
            end
        endcase
        r.value    = val[VALUE_W-1:0];
        r.in_scale = hit;
        r.req      = req;
        r.pitch    = pitch;
        r.amount   = amount;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int wanted, input int seen);
        $display("%0t: %s wrong for request %0d pitch %0d amount %0d: expected %0d, got %0d",
                 $time, what, due.req, due.pitch, $signed(due.amount), wanted, seen);
        o_failures++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scale_root = '0;
            scale_kind = KIND_MAJOR;
            due_head   = 0;
            due_tail   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ROOT) begin
                    scale_root = i_cfg_data[ROOT_W-1:0];
                end else if (i_cfg_index == CFG_KIND) begin
                    scale_kind = i_cfg_data[KIND_W-1:0];
                end
            end
            if (i_res_valid && i_res_ready) begin
                if (due_tail == due_head) begin
                    due = '0;
                    report_mismatch("unrequested result", 0, int'(i_res_data));
                end else begin
                    due = due_buf[due_head % DUE_DEPTH];
                    due_head++;
                    o_checked++;
                    if (due.in_scale) begin
                        o_in_scale++;
                    end
                    if (i_res_data !== {{(OUT_DATA_W-VALUE_W){1'b0}}, due.value}) begin
                        report_mismatch("result_value", int'($signed(due.value)),
                                        int'($signed(i_res_data[VALUE_W-1:0])));
                    end
                    if (i_res_user !== due.in_scale) begin
                        report_mismatch("in_scale", int'(due.in_scale), int'(i_res_user));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (due_tail - due_head >= DUE_DEPTH) begin
                    due = map_scale_request(i_req_user, i_req_data[PITCH_W-1:0],
                                            i_req_data[PITCH_W +: AMOUNT_W],
                                            scale_root, scale_kind);
                    report_mismatch("result backlog", DUE_DEPTH, due_tail - due_head);
                end else begin
                    due_buf[due_tail % DUE_DEPTH] = map_scale_request(i_req_user,
                                                        i_req_data[PITCH_W-1:0],
                                                        i_req_data[PITCH_W +: AMOUNT_W],
                                                        scale_root, scale_kind);
                    due_tail++;
                end
            end
        end
        o_pending = due_tail - due_head;
    end

endmodule

// ----- tb/scale_degree_pitch_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Scale degree pitch unit testbench
// Drives directed and random requests through the scale degree pitch unit
// under a series of scale settings, with random gaps on the request side and
// random stalls on the result side. A checker beside the unit predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scale_degree_pitch_unit_tb;

    import sdp_pkg::*;

    localparam logic [REQ_W-1:0]  REQ_UNUSED  = 2'd3;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 190;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic [REQ_W-1:0]        s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    int   pending;
    int   failures;
    int   checked;
    int   in_scale_count;
    int   settings;
    logic sink_stalls;

    scale_degree_pitch_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    scale_degree_pitch_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_res_user  (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_failures  (failures),
        .o_checked   (checked),
        .o_in_scale  (in_scale_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: random stall bursts while enabled, otherwise always ready.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stalls && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // Each task starts and ends right after a falling edge; valid stays high
    // between back-to-back requests.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [PITCH_W-1:0] pitch,
                                input int amount);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, 8'(amount), pitch};
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic pause_requests(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_scale(input logic [CFG_DATA_W-1:0] root,
                             input logic [CFG_DATA_W-1:0] kind_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ROOT;
        i_cfg_data  <= root;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= CFG_KIND;
        i_cfg_data  <= kind_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin : stimulus
        int                   ph;
        int                   k;
        int                   sel;
        int                   amount;
        logic                 source_gaps;
        logic [REQ_W-1:0]     req;
        logic [PITCH_W-1:0]   pitch;
        logic [CFG_DATA_W-1:0] root;
        logic [CFG_DATA_W-1:0] kind_data;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_TO_PITCH;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_ROOT;
        i_cfg_data    = '0;
        sink_stalls   = 1'b0;
        source_gaps   = 1'b0;
        settings      = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests in C major straight after reset.
        send_request(REQ_TO_PITCH, 0, -128);
        send_request(REQ_TO_PITCH, 127, 0);
        send_request(REQ_TO_PITCH, 0, 1);
        send_request(REQ_TO_PITCH, 0, 8);
        send_request(REQ_TO_PITCH, 0, 127);
        send_request(REQ_TO_DEGREE, 0, 0);
        send_request(REQ_TO_DEGREE, 127, -1);
        send_request(REQ_TO_DEGREE, 61, 0);
        send_request(REQ_TO_DEGREE, 71, 5);
        send_request(REQ_TRANSPOSE, 60, 0);
        send_request(REQ_TRANSPOSE, 60, 127);
        send_request(REQ_TRANSPOSE, 127, -128);
        send_request(REQ_TRANSPOSE, 61, 3);
        send_request(REQ_TRANSPOSE, 2, -3);
        send_request(REQ_TRANSPOSE, 0, -1);
        send_request(REQ_UNUSED, 127, -1);

        // Unused scale kind with a root beyond B, then a pentatonic scale.
        drain();
        set_scale(4'd15, {2'b11, KIND_UNUSED});
        send_request(REQ_TRANSPOSE, 3, -1);
        send_request(REQ_TRANSPOSE, 15, -8);
        send_request(REQ_TO_PITCH, 0, -5);
        send_request(REQ_TO_DEGREE, 127, 0);
        send_request(REQ_TRANSPOSE, 126, 127);
        drain();
        set_scale(4'd11, {2'b00, KIND_PENTA});
        send_request(REQ_TRANSPOSE, 11, -1);
        send_request(REQ_TRANSPOSE, 14, -6);
        send_request(REQ_TO_PITCH, 0, 5);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin root = 4'd0;  kind_data = {2'b00, KIND_MAJOR}; end
                1: begin root = 4'd11; kind_data = {2'b00, KIND_MINOR}; end
                2: begin root = 4'd15; kind_data = {2'b00, KIND_PENTA}; end
                3: begin root = 4'd12; kind_data = {2'b00, KIND_UNUSED}; end
                default: begin
                    root = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(12, 15))
                                                       : 4'($urandom_range(0, 11));
                    kind_data = 4'($urandom_range(0, 3));
                    if ($urandom_range(0, 5) == 0) begin
                        kind_data[3:2] = 2'($urandom_range(1, 3));
                    end
                end
            endcase
            drain();
            set_scale(root, kind_data);
            source_gaps = (ph < PHASES - 1) && (ph % 3 != 2);
            sink_stalls = (ph < PHASES - 1) && (ph % 4 != 3);
            for (k = 0; k < PHASE_REQS; k++) begin
                if (source_gaps && $urandom_range(0, 3) == 0) begin
                    pause_requests($urandom_range(1, 13));
                end
                sel = $urandom_range(0, 9);
                req = (sel < 3) ? REQ_TO_PITCH : (sel < 6) ? REQ_TO_DEGREE :
                      (sel < 9) ? REQ_TRANSPOSE : REQ_UNUSED;
                pitch = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 23))
                                                    : 7'($urandom_range(0, 127));
                if ($urandom_range(0, 7) == 0) begin
                    amount = int'($signed(8'($urandom_range(0, 255))));
                end else begin
                    amount = int'($urandom_range(0, 40)) - 20;
                end
                send_request(req, pitch, amount);
            end
        end

        drain();
        repeat (10) @(negedge i_clk);
        $display("Checked %0d results over %0d scale settings; %0d of them landed on a scale note.",
                 checked, settings, in_scale_count);
        if (failures == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
